[src/kmgd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmgd_pkg: shared types and constants
// Item structs, board geometry, knight offsets and register indexes.
// ----------------------------------------------------------------------------
package kmgd_pkg;

  localparam int MaxSide = 128;
  localparam int SideW   = $clog2(MaxSide);
  localparam int AddrW   = 2 * SideW;
  localparam int CellCnt = MaxSide * MaxSide;
  localparam int CountW  = 14;
  localparam int MoveCnt = 8;

  // configuration register indexes
  localparam logic RegBoardRows = 1'b0;
  localparam logic RegBoardCols = 1'b1;

  localparam logic signed [2:0] KnightDRow [MoveCnt] = '{3'sd1, 3'sd2, 3'sd2, 3'sd1,
                                                          -3'sd1, -3'sd2, -3'sd2, -3'sd1};
  localparam logic signed [2:0] KnightDCol [MoveCnt] = '{3'sd2, 3'sd1, -3'sd1, -3'sd2,
                                                          -3'sd2, -3'sd1, 3'sd1, 3'sd2};

  typedef struct packed {
    logic [7:0] start_row;
    logic [7:0] start_col;
    logic [7:0] target_row;
    logic [7:0] target_col;
  } in_item_t;

  typedef struct packed {
    logic [CountW-1:0] jump_count;
    logic              unreachable;
  } out_item_t;

  // one map entry: visited flag and the level it was reached at
  typedef struct packed {
    logic              vis;
    logic [CountW-1:0] lvl;
  } cell_t;

  // one-based row and column to memory address
  function automatic logic [AddrW-1:0] cell_addr(logic [7:0] r, logic [7:0] c);
    logic [7:0] rm;
    logic [7:0] cm;
    rm = r - 8'd1;
    cm = c - 8'd1;
    return {rm[SideW-1:0], cm[SideW-1:0]};
  endfunction

endpackage

[src/knight_move_grid_distance.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knight_move_grid_distance: fewest knight jumps between two cells
// Level-by-level breadth-first sweep over a cell map held in one RAM.
// ----------------------------------------------------------------------------
// Takes one item at a time. Each item first clears the 16384-entry cell map,
// then sweeps every cell in use once per BFS level: each cell is read and
// then evaluated, and each knight move of a frontier cell is read and, if on
// the board, evaluated. The single-port-pair cell RAM, one access per cycle,
// sets the pace. Off-board cells give an answer from the check step right
// after the clear, without a sweep. A finished result sits in an output
// register while the next item is accepted.
module knight_move_grid_distance (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  kmgd_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output kmgd_pkg::out_item_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [7:0]           cfg_data_i
);

  typedef enum logic [3:0] {
    StIdle, StClear, StCheck, StScanRd, StScanEv, StMoveRd, StMoveEv, StLevelEnd, StFin
  } state_e;

  state_e state_q;
  logic [7:0] rows_q, cols_q;
  kmgd_pkg::in_item_t item_q;
  logic [kmgd_pkg::AddrW-1:0] clr_q;
  logic [7:0] cur_r_q, cur_c_q;
  logic [2:0] k_q;
  logic [kmgd_pkg::CountW-1:0] lvl_q;
  logic grew_q, found_q;
  logic [kmgd_pkg::CountW-1:0] fin_cnt_q;
  logic fin_unr_q;
  logic out_valid_q;
  kmgd_pkg::out_item_t out_q;

  // cell map RAM
  kmgd_pkg::cell_t mem [kmgd_pkg::CellCnt];
  kmgd_pkg::cell_t rdata_q;
  logic mem_we, mem_re;
  logic [kmgd_pkg::AddrW-1:0] waddr, raddr;
  kmgd_pkg::cell_t wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  // sides in use, clamped to the map size
  logic [7:0] nr, nc;
  assign nr = (rows_q > 8'(kmgd_pkg::MaxSide)) ? 8'(kmgd_pkg::MaxSide) : rows_q;
  assign nc = (cols_q > 8'(kmgd_pkg::MaxSide)) ? 8'(kmgd_pkg::MaxSide) : cols_q;

  function automatic logic on_board(logic [7:0] r, logic [7:0] c, logic [7:0] mr,
                                    logic [7:0] mc);
    return (r != 8'd0) && (r <= mr) && (c != 8'd0) && (c <= mc);
  endfunction

  // neighbor of the current cell for move k
  logic signed [8:0] nb_r, nb_c;
  logic nb_ok;
  logic [2:0] dr, dc;
  assign dr = kmgd_pkg::KnightDRow[k_q];
  assign dc = kmgd_pkg::KnightDCol[k_q];
  assign nb_r = $signed({1'b0, cur_r_q}) + $signed({{6{dr[2]}}, dr});
  assign nb_c = $signed({1'b0, cur_c_q}) + $signed({{6{dc[2]}}, dc});
  assign nb_ok = !nb_r[8] && !nb_c[8] && on_board(nb_r[7:0], nb_c[7:0], nr, nc);

  logic last_cell, last_move;
  assign last_cell = (cur_r_q == nr) && (cur_c_q == nc);
  assign last_move = (k_q == 3'(kmgd_pkg::MoveCnt - 1));

  // memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    waddr  = clr_q;
    raddr  = kmgd_pkg::cell_addr(cur_r_q, cur_c_q);
    wdata  = '0;
    unique case (state_q)
      StClear: begin
        mem_we = 1'b1;
      end
      StCheck: begin
        mem_we = 1'b1;
        waddr  = kmgd_pkg::cell_addr(item_q.start_row, item_q.start_col);
        wdata  = '{vis: 1'b1, lvl: '0};
      end
      StScanRd: begin
        mem_re = 1'b1;
      end
      StMoveRd: begin
        mem_re = nb_ok;
        raddr  = kmgd_pkg::cell_addr(nb_r[7:0], nb_c[7:0]);
      end
      StMoveEv: begin
        mem_we = !rdata_q.vis;
        waddr  = kmgd_pkg::cell_addr(nb_r[7:0], nb_c[7:0]);
        wdata  = '{vis: 1'b1, lvl: lvl_q + 1'b1};
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 8'd8;
      cols_q <= 8'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kmgd_pkg::RegBoardRows: rows_q <= cfg_data_i;
        kmgd_pkg::RegBoardCols: cols_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      item_q      <= '0;
      clr_q       <= '0;
      cur_r_q     <= 8'd1;
      cur_c_q     <= 8'd1;
      k_q         <= '0;
      lvl_q       <= '0;
      grew_q      <= 1'b0;
      found_q     <= 1'b0;
      fin_cnt_q   <= '0;
      fin_unr_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // output register: load from finish, else drop on accept
      if (state_q == StFin && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            clr_q   <= '0;
            state_q <= StClear;
          end
        end
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= StCheck;
          end
        end
        StCheck: begin
          cur_r_q <= 8'd1;
          cur_c_q <= 8'd1;
          lvl_q   <= '0;
          grew_q  <= 1'b0;
          found_q <= 1'b0;
          if (!on_board(item_q.start_row, item_q.start_col, nr, nc) ||
              !on_board(item_q.target_row, item_q.target_col, nr, nc)) begin
            fin_cnt_q <= '0;
            fin_unr_q <= 1'b1;
            state_q   <= StFin;
          end else if (item_q.start_row == item_q.target_row &&
                       item_q.start_col == item_q.target_col) begin
            fin_cnt_q <= '0;
            fin_unr_q <= 1'b0;
            state_q   <= StFin;
          end else begin
            state_q <= StScanRd;
          end
        end
        StScanRd: begin
          state_q <= StScanEv;
        end
        StScanEv: begin
          k_q <= '0;
          if (rdata_q.vis && rdata_q.lvl == lvl_q) begin
            state_q <= StMoveRd;
          end else if (last_cell) begin
            state_q <= StLevelEnd;
          end else begin
            state_q <= StScanRd;
            if (cur_c_q == nc) begin
              cur_c_q <= 8'd1;
              cur_r_q <= cur_r_q + 8'd1;
            end else begin
              cur_c_q <= cur_c_q + 8'd1;
            end
          end
        end
        StMoveRd: begin
          if (nb_ok) begin
            state_q <= StMoveEv;
          end else if (!last_move) begin
            k_q <= k_q + 3'd1;
          end else if (last_cell) begin
            state_q <= StLevelEnd;
          end else begin
            state_q <= StScanRd;
            if (cur_c_q == nc) begin
              cur_c_q <= 8'd1;
              cur_r_q <= cur_r_q + 8'd1;
            end else begin
              cur_c_q <= cur_c_q + 8'd1;
            end
          end
        end
        StMoveEv: begin
          if (!rdata_q.vis) begin
            grew_q <= 1'b1;
            if (nb_r[7:0] == item_q.target_row && nb_c[7:0] == item_q.target_col) begin
              found_q <= 1'b1;
            end
          end
          if (!last_move) begin
            k_q     <= k_q + 3'd1;
            state_q <= StMoveRd;
          end else if (last_cell) begin
            state_q <= StLevelEnd;
          end else begin
            state_q <= StScanRd;
            if (cur_c_q == nc) begin
              cur_c_q <= 8'd1;
              cur_r_q <= cur_r_q + 8'd1;
            end else begin
              cur_c_q <= cur_c_q + 8'd1;
            end
          end
        end
        StLevelEnd: begin
          cur_r_q <= 8'd1;
          cur_c_q <= 8'd1;
          grew_q  <= 1'b0;
          if (found_q) begin
            fin_cnt_q <= lvl_q + 1'b1;
            fin_unr_q <= 1'b0;
            state_q   <= StFin;
          end else if (!grew_q) begin
            fin_cnt_q <= '0;
            fin_unr_q <= 1'b1;
            state_q   <= StFin;
          end else begin
            lvl_q   <= lvl_q + 1'b1;
            state_q <= StScanRd;
          end
        end
        StFin: begin
          // wait for the output register to be free
          if (!out_valid_q || !out_stall_i) begin
            out_q   <= '{jump_count: fin_cnt_q, unreachable: fin_unr_q};
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // the map is only written while an item is being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q != StIdle && state_q != StFin))
    else $error("cell map written outside an item");

  // a new result comes only from the finish step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StFin))
    else $error("result raised outside finish");

  // unreachable results carry a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.unreachable || out_data_o.jump_count == '0))
    else $error("unreachable result with nonzero count");
`endif

endmodule

[dv/kmgd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmgd_checker: result predictor and scoreboard for knight distance
// Watches the item channels and the register port, computes the fewest
// knight jumps for each accepted item and compares with the block's results.
// ----------------------------------------------------------------------------
module kmgd_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  kmgd_pkg::in_item_t   in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  kmgd_pkg::out_item_t  out_data_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  output int                   err_cnt_o,
  output int                   pending_o
);

  logic [7:0] rows_q;
  logic [7:0] cols_q;
  kmgd_pkg::out_item_t dist_q [$];

  // clip a configured side to the map size
  function automatic int side_of(logic [7:0] v);
    return (v > kmgd_pkg::MaxSide) ? kmgd_pkg::MaxSide : int'(v);
  endfunction

  // BFS over knight moves; one level at a time
  function automatic kmgd_pkg::out_item_t knight_dist(kmgd_pkg::in_item_t it,
                                                      logic [7:0] nr8, logic [7:0] nc8);
    bit        seen [kmgd_pkg::MaxSide][kmgd_pkg::MaxSide];
    bit        cur  [kmgd_pkg::MaxSide][kmgd_pkg::MaxSide];
    bit        nxt  [kmgd_pkg::MaxSide][kmgd_pkg::MaxSide];
    int        nr;
    int        nc;
    int        sr;
    int        sc;
    int        tr;
    int        tc;
    int        lvl;
    int        rr;
    int        cc;
    bit        grew;
    kmgd_pkg::out_item_t res;
    nr  = side_of(nr8);
    nc  = side_of(nc8);
    sr  = it.start_row;
    sc  = it.start_col;
    tr  = it.target_row;
    tc  = it.target_col;
    res = '{jump_count: '0, unreachable: 1'b1};
    if (sr < 1 || sr > nr || sc < 1 || sc > nc || tr < 1 || tr > nr || tc < 1 || tc > nc)
      return res;
    seen[sr-1][sc-1] = 1;
    cur[sr-1][sc-1]  = 1;
    lvl = 0;
    forever begin
      if (cur[tr-1][tc-1]) begin
        res.jump_count  = lvl[kmgd_pkg::CountW-1:0];
        res.unreachable = 1'b0;
        return res;
      end
      grew = 0;
      for (int r = 0; r < nr; r++)
        for (int c = 0; c < nc; c++) nxt[r][c] = 0;
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          if (!cur[r][c]) continue;
          for (int k = 0; k < kmgd_pkg::MoveCnt; k++) begin
            rr = r + kmgd_pkg::KnightDRow[k];
            cc = c + kmgd_pkg::KnightDCol[k];
            if (rr >= 0 && rr < nr && cc >= 0 && cc < nc && !seen[rr][cc]) begin
              seen[rr][cc] = 1;
              nxt[rr][cc]  = 1;
              grew = 1;
            end
          end
        end
      end
      if (!grew) return res;
      cur = nxt;
      if (lvl < 16383) lvl++;
    end
  endfunction

  assign pending_o = dist_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q    <= 8'd8;
      cols_q    <= 8'd8;
      err_cnt_o <= 0;
      dist_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == kmgd_pkg::RegBoardRows) rows_q <= cfg_data_i;
        else                                     cols_q <= cfg_data_i;
      end
      // result compare against oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (dist_q.size() == 0) begin
          if (err_cnt_o < 10) $display("unexpected result %p", out_data_i);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          if (out_data_i.jump_count !== dist_q[0].jump_count ||
              out_data_i.unreachable !== dist_q[0].unreachable) begin
            if (err_cnt_o < 10)
              $display("mismatch: exp jumps %0d unr %0b, got jumps %0d unr %0b",
                       dist_q[0].jump_count, dist_q[0].unreachable,
                       out_data_i.jump_count, out_data_i.unreachable);
            err_cnt_o <= err_cnt_o + 1;
          end
          void'(dist_q.pop_front());
        end
      end
      if (in_valid_i && !in_stall_i)
        dist_q.push_back(knight_dist(in_data_i, rows_q, cols_q));
    end
  end
endmodule

[dv/knight_move_grid_distance_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knight_move_grid_distance_test: stimulus and verdict
// Drives start and target cells over several board shapes with random idle
// gaps and receiver stalls; the checker scores every result.
// ----------------------------------------------------------------------------
module knight_move_grid_distance_test;

  localparam longint CycleLimit = 64'd60_000_000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  kmgd_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  kmgd_pkg::out_item_t out_data;
  logic      cfg_we;
  logic      cfg_idx;
  logic [7:0] cfg_data;
  int        err_cnt;
  int        pending;
  longint    cycle_cnt;
  bit        hold_off;
  bit        hold_done;

  knight_move_grid_distance i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  kmgd_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("[knight_move_grid_distance] ERROR");
      $finish;
    end
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
  endfunction

  // receiver: random stall stretches, one long hold-off on request
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off && !hold_done) begin
        out_stall <= 1'b1;
        for (int i = 0; i < 400000; i++) @(posedge clk);
        hold_done = 1;
      end
      n = gap_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  task automatic send_item(logic [7:0] sr, logic [7:0] sc, logic [7:0] tr, logic [7:0] tc);
    in_valid <= 1'b1;
    in_data  <= '{start_row: sr, start_col: sc, target_row: tr, target_col: tc};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 1'b0;
    repeat (gap_len()) @(posedge clk);
  endtask

  // let the last accepted item reach the scoreboard before polling it
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20000) @(posedge clk);
  endtask

  task automatic set_board(logic [7:0] r, logic [7:0] c);
    drain();
    cfg_we <= 1'b1; cfg_idx <= kmgd_pkg::RegBoardRows; cfg_data <= r;
    @(posedge clk);
    cfg_idx <= kmgd_pkg::RegBoardCols; cfg_data <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // random cell, mostly on the board, sometimes anywhere
  function automatic logic [7:0] pick(int side);
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(1, (side < 1) ? 1 : ((side > 128) ? 128 : side)));
  endfunction

  task automatic random_items(int cnt, int nr, int nc);
    for (int i = 0; i < cnt; i++)
      send_item(pick(nr), pick(nc), pick(nr), pick(nc));
  endtask

  initial begin
    int sides [6] = '{1, 3, 5, 8, 12, 20};
    cycle_cnt = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = kmgd_pkg::RegBoardRows;
    cfg_data  = '0;
    hold_off  = 0;
    hold_done = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed on the reset 8x8 board
    send_item(1, 1, 1, 1);
    send_item(1, 1, 8, 8);
    send_item(1, 1, 2, 2);
    send_item(0, 1, 3, 3);
    send_item(1, 9, 3, 3);
    send_item(255, 255, 255, 255);
    send_item(4, 4, 0, 0);
    send_item(8, 1, 1, 8);
    // 3x3 board: center unreachable
    set_board(3, 3);
    send_item(1, 1, 2, 2);
    send_item(1, 1, 3, 3);
    // empty and oversized boards
    set_board(0, 5);
    send_item(1, 1, 1, 1);
    set_board(5, 0);
    send_item(1, 1, 1, 1);
    set_board(255, 1);
    send_item(1, 1, 128, 1);
    send_item(1, 1, 1, 1);
    set_board(128, 128);
    send_item(1, 1, 128, 128);
    send_item(128, 128, 127, 126);
    send_item(64, 64, 1, 1);
    set_board(1, 128);
    send_item(1, 1, 1, 128);
    send_item(1, 5, 1, 5);

    // long receiver hold-off while items keep coming
    set_board(6, 7);
    hold_off = 1;
    random_items(10, 6, 7);
    while (!hold_done) @(posedge clk);
    // sender pause until empty
    drain();

    // random part over several board shapes
    for (int p = 0; p < 6; p++) begin
      set_board(8'(sides[p]), 8'(sides[(p + 3) % 6]));
      random_items(14, sides[p], sides[(p + 3) % 6]);
    end
    set_board(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_items(2, 128, 128);

    drain();
    if (err_cnt == 0) begin
      $display("[knight_move_grid_distance] OK");
    end else begin
      $display("[knight_move_grid_distance] ERROR");
    end
    $finish;
  end
endmodule
